/* rtl/core/tvdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvdc_pkg: shared types and constants
// Word formats, register indexes and controller/datapath handshake types for
// the terrain vertex dedup cache.
// ----------------------------------------------------------------------------
package tvdc_pkg;

  localparam int unsigned FIELD_W   = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CELL_W    = 12;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned SADDR_W   = 24;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned GC_W      = CELL_W + (1 << LEVEL_W) - 1;
  localparam int unsigned PROD_W    = 2 * FIELD_W;
  localparam int unsigned HSUM_W    = PROD_W + 1;

  localparam logic               CACHE_EN_RST = 1'b1;
  localparam logic [FIELD_W-1:0] FIELD_RST    = 13'd1025;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_VERTEX = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CACHE_EN = 2'd0,
    CFG_FIELD_W  = 2'd1,
    CFG_FIELD_H  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RES_LOAD = 2'd0,
    RES_HIT  = 2'd1,
    RES_FULL = 2'd2,
    RES_NEW  = 2'd3
  } res_kind_e;

  typedef struct packed {
    logic               func;
    logic [LEVEL_W-1:0] level;
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_z;
    logic [SADDR_W-1:0] sample_addr;
    logic [WORD_W-1:0]  sample_value;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] vertex_index;
    logic [WORD_W-1:0] vertex_height;
    logic              cache_hit;
    logic              store_full;
  } out_word_t;

  typedef struct packed {
    logic      capture;
    logic      hs_wr;
    logic      lut_rd;
    logic      ent_rd;
    logic      ent_last;
    logic      hs_rd;
    logic      commit;
    logic      out_load;
    res_kind_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic hit;
    logic full;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/terrain_vertex_dedup_cache_top.sv */
`timescale 1ns / 1ps
// A vertex request runs the probe, entry and check states, a load the load state,
// then the result state, which waits until the output register is free. The next
// word waits for the dependent reads (lookup table, entry arrays, height store).
// A finished result waits in the output register while the next word is taken.
// Reset: count and configuration reset at once; no clearing pass, since a lookup
// slot only counts when its index is below the entry count.
// ----------------------------------------------------------------------------
// terrain_vertex_dedup_cache_top: terrain vertex dedup cache
// Scales cell coordinates by level, probes a direct-mapped index table and
// appends new vertices with their height word; loads write the height store.
// ----------------------------------------------------------------------------
module terrain_vertex_dedup_cache_top
  import tvdc_pkg::*;
#(
  parameter int unsigned ENTRY_LIMIT   = 65000,
  parameter int unsigned LOOKUP_BITS   = 9,
  parameter int unsigned MAP_ADDR_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FIELD_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tvdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tvdc_datapath #(
    .ENTRY_LIMIT   (ENTRY_LIMIT),
    .LOOKUP_BITS   (LOOKUP_BITS),
    .MAP_ADDR_BITS (MAP_ADDR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* rtl/core/tvdc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvdc_ctrl: request sequencer
// Steps each vertex word through probe, entry check, height read or full
// handling, and the final result/commit cycle; loads do a height write first.
// ----------------------------------------------------------------------------
module tvdc_ctrl
  import tvdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PROBE,
    S_ENTRY,
    S_CHECK,
    S_FIN
  } state_e;

  state_e    state_q, state_d;
  res_kind_e kind_q, kind_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.kind = kind_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = status_i.is_load ? S_LOAD : S_PROBE;
        end
      end
      S_LOAD: begin
        cmd_o.hs_wr = 1'b1;
        kind_d  = RES_LOAD;
        state_d = S_FIN;
      end
      S_PROBE: begin
        cmd_o.lut_rd = 1'b1;
        state_d = S_ENTRY;
      end
      S_ENTRY: begin
        cmd_o.ent_rd = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.hit) begin
          kind_d = RES_HIT;
        end else if (status_i.full) begin
          cmd_o.ent_rd   = 1'b1;
          cmd_o.ent_last = 1'b1;
          kind_d = RES_FULL;
        end else begin
          cmd_o.hs_rd = 1'b1;
          kind_d = RES_NEW;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.commit   = (kind_q == RES_NEW);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= RES_LOAD;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

/* rtl/core/tvdc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvdc_datapath: tables, entry store, height store and result register
// Holds configuration, the lookup table, entry arrays, height memory, the
// entry count and the output word.
// ----------------------------------------------------------------------------
module tvdc_datapath
  import tvdc_pkg::*;
#(
  parameter int unsigned ENTRY_LIMIT   = 65000,
  parameter int unsigned LOOKUP_BITS   = 9,
  parameter int unsigned MAP_ADDR_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FIELD_W-1:0]   cfg_wdata_i,
  input  in_word_t             in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output out_word_t            out_data_o,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o
);

  localparam int unsigned IDX_W     = (ENTRY_LIMIT > 1) ? $clog2(ENTRY_LIMIT) : 1;
  localparam int unsigned CNT_W     = $clog2(ENTRY_LIMIT + 1);
  localparam int unsigned KEY_W     = 2 * LOOKUP_BITS;
  localparam int unsigned LUT_DEPTH = 1 << KEY_W;
  localparam int unsigned MAP_WORDS = 1 << MAP_ADDR_BITS;

  logic               cache_en_q;
  logic [FIELD_W-1:0] field_w_q;
  logic [FIELD_W-1:0] field_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_en_q <= CACHE_EN_RST;
      field_w_q  <= FIELD_RST;
      field_h_q  <= FIELD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CACHE_EN: cache_en_q <= cfg_wdata_i[0];
        CFG_FIELD_W:  field_w_q  <= cfg_wdata_i;
        CFG_FIELD_H:  field_h_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  in_word_t           req_q;
  logic [GC_W-1:0]    gx_q, gz_q;
  logic [KEY_W-1:0]   key;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
      gx_q  <= GC_W'(in_data_i.cell_x) << in_data_i.level;
      gz_q  <= GC_W'(in_data_i.cell_z) << in_data_i.level;
    end
  end

  assign key = {gx_q[LOOKUP_BITS-1:0], gz_q[LOOKUP_BITS-1:0]};

  // clamp and address arithmetic, one register stage each
  logic [FIELD_W-1:0] lim_x, lim_z, sx_q, sz_q;
  logic [PROD_W-1:0]  prod_q;
  logic [HSUM_W-1:0]  hsum;

  assign lim_x = (field_w_q == '0) ? '0 : field_w_q - 1'b1;
  assign lim_z = (field_h_q == '0) ? '0 : field_h_q - 1'b1;

  always_ff @(posedge clk_i) begin
    sx_q   <= (gx_q < GC_W'(lim_x)) ? gx_q[FIELD_W-1:0] : lim_x;
    sz_q   <= (gz_q < GC_W'(lim_z)) ? gz_q[FIELD_W-1:0] : lim_z;
    prod_q <= PROD_W'(sz_q) * PROD_W'(field_w_q);
  end

  assign hsum = HSUM_W'(prod_q) + HSUM_W'(sx_q);

  // entry count
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] new_idx;

  assign count_m1 = count_q - 1'b1;
  assign new_idx  = count_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_q + 1'b1;
    end
  end

  // lookup table; stale slots are screened by the count compare
  logic [IDX_W-1:0] lut_mem [LUT_DEPTH];
  logic [IDX_W-1:0] lut_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lut_rd) begin
      lut_idx_q <= lut_mem[key];
    end
    if (cmd_i.commit) begin
      lut_mem[key] <= new_idx;
    end
  end

  // entry arrays
  logic [WORD_W-1:0] ent_x_mem [ENTRY_LIMIT];
  logic [WORD_W-1:0] ent_z_mem [ENTRY_LIMIT];
  logic [WORD_W-1:0] ent_h_mem [ENTRY_LIMIT];
  logic [WORD_W-1:0] ent_x_q, ent_z_q, ent_h_q;
  logic [IDX_W-1:0]  ent_addr;
  logic [WORD_W-1:0] hs_q;

  assign ent_addr = cmd_i.ent_last ? count_m1[IDX_W-1:0] : lut_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_rd) begin
      ent_x_q <= ent_x_mem[ent_addr];
    end
    if (cmd_i.commit) begin
      ent_x_mem[new_idx] <= gx_q[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_rd) begin
      ent_z_q <= ent_z_mem[ent_addr];
    end
    if (cmd_i.commit) begin
      ent_z_mem[new_idx] <= gz_q[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_rd) begin
      ent_h_q <= ent_h_mem[ent_addr];
    end
    if (cmd_i.commit) begin
      ent_h_mem[new_idx] <= hs_q;
    end
  end

  // height store
  logic [WORD_W-1:0] hs_mem [MAP_WORDS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.hs_rd) begin
      hs_q <= hs_mem[hsum[MAP_ADDR_BITS-1:0]];
    end
    if (cmd_i.hs_wr) begin
      hs_mem[req_q.sample_addr[MAP_ADDR_BITS-1:0]] <= req_q.sample_value;
    end
  end

  // status
  logic hit;

  assign hit = cache_en_q && (CNT_W'(lut_idx_q) < count_q) &&
               (GC_W'(ent_x_q) == gx_q) && (GC_W'(ent_z_q) == gz_q);

  // result register
  logic      out_valid_q;
  out_word_t out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_d = '0;
    case (cmd_i.kind)
      RES_HIT: begin
        out_d.vertex_index  = WORD_W'(lut_idx_q);
        out_d.vertex_height = ent_h_q;
        out_d.cache_hit     = 1'b1;
      end
      RES_FULL: begin
        out_d.vertex_index  = WORD_W'(count_m1[IDX_W-1:0]);
        out_d.vertex_height = ent_h_q;
        out_d.store_full    = 1'b1;
      end
      RES_NEW: begin
        out_d.vertex_index  = WORD_W'(new_idx);
        out_d.vertex_height = hs_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.is_load  = (in_data_i.func == FUNC_LOAD);
  assign status_o.hit      = hit;
  assign status_o.full     = (count_q >= CNT_W'(ENTRY_LIMIT));
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

/* rtl/core/tvdc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvdc_checker: port-level checks
// Watches the top-level ports of the dedup cache.
// ----------------------------------------------------------------------------
module tvdc_checker
  import tvdc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input out_word_t            out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result word changed while stalled");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.cache_hit && out_data_o.store_full))
    else $error("hit and full flagged together");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("new word taken while one is in flight");

endmodule

bind terrain_vertex_dedup_cache_top tvdc_checker u_tvdc_checker (.*);
